### rtl/pal_pkg.sv
// pal_pkg: operation codes, status codes, port widths and the cell command type
// for the positional array list. No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int FUNC_W   = 4;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 7;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_GET        = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SET        = 4'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd3;
    localparam logic [FUNC_W-1:0] FN_PUSH       = 4'd4;
    localparam logic [FUNC_W-1:0] FN_POP_END    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_POP_START  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_PEEK_END   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_PEEK_START = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // broadcast to every cell; at most one bit set
    typedef struct packed {
        logic ins;  // open a gap at pos, write there, shift upper cells up
        logic rem;  // shift cells at and above pos down
        logic wr;   // overwrite the cell at pos
    } pal_cmd_t;

endpackage

### rtl/pal_cell.sv
// pal_cell: one storage cell of the list row; takes data from its lower or
// upper neighbour, or the write word, as the broadcast command says. Uses pal_pkg.
`timescale 1ns / 1ps

module pal_cell #(
    parameter int CNT_W     = 7,
    parameter int ELEM_BITS = 32,
    parameter int IDX       = 0
) (
    input  logic                  clk,
    input  pal_pkg::pal_cmd_t     cmd,
    input  logic [CNT_W-1:0]      pos,
    input  logic [ELEM_BITS-1:0]  wdata,
    input  logic [ELEM_BITS-1:0]  lower,
    input  logic [ELEM_BITS-1:0]  upper,
    output logic [ELEM_BITS-1:0]  q,
    output logic [ELEM_BITS-1:0]  rd
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [ELEM_BITS-1:0] q_reg;
    logic [ELEM_BITS-1:0] q_next;
    logic                 hit;

    assign hit = (pos == MY_IDX);

    always_comb
    begin
        q_next = q_reg;
        if (cmd.ins)
        begin
            if (hit)
                q_next = wdata;
            else if (MY_IDX > pos)
                q_next = lower;
        end
        else if (cmd.rem)
        begin
            if (MY_IDX >= pos)
                q_next = upper;
        end
        else if (cmd.wr && hit)
        begin
            q_next = wdata;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q  = q_reg;
    assign rd = hit ? q_reg : '0;

endmodule

### rtl/positional_array_list_unit.sv
// The result of each accepted item is registered in the output register.
// Throughput: one item per cycle while in_ready is high; every insert or remove
// moves the whole cell row at once, and a read ORs the one selected cell into
// the output. in_ready falls only while a result waits and out_ready is low.
// Reset: fill count cleared, capacity set to DEPTH or the largest CFG_W value if
// smaller, no result pending; cell contents are left undefined until written.
`timescale 1ns / 1ps

module positional_array_list_unit #(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pal_pkg::FUNC_W-1:0]      func,
    input  logic [pal_pkg::POS_W-1:0]       position,
    input  logic [pal_pkg::DATA_W-1:0]      data_in,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pal_pkg::DATA_W-1:0]      data_out,
    output logic [pal_pkg::STATUS_W-1:0]    status,
    output logic [pal_pkg::COUNT_W-1:0]     count,
    // capacity register
    input  logic                            cfg_wr_en,
    input  logic [pal_pkg::CFG_W-1:0]       cfg_wr_data
);

    // count width holds DEPTH itself; compare width also holds any position
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = ((CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W) + 1;
    localparam int CFG_MAX = (1 << pal_pkg::CFG_W) - 1;
    localparam int CAP_RST = (DEPTH > CFG_MAX) ? CFG_MAX : DEPTH;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [pal_pkg::CFG_W-1:0]     max_entries_reg;
    logic                          out_valid_reg;

    // result register, payload only
    logic [pal_pkg::DATA_W-1:0]    data_out_reg;
    logic [pal_pkg::STATUS_W-1:0]  status_reg;
    logic [pal_pkg::COUNT_W-1:0]   count_out_reg;

    logic                          accept;
    logic [CMP_W-1:0]              cnt_ext;
    logic [CMP_W-1:0]              pos_ext;
    logic [CMP_W-1:0]              last_ext;
    logic [CMP_W-1:0]              cap_ext;
    logic [CMP_W-1:0]              max_ext;
    logic [CMP_W-1:0]              epos;
    logic [pal_pkg::STATUS_W-1:0]  st;
    logic                          rd_en;
    pal_pkg::pal_cmd_t             cmd;
    pal_pkg::pal_cmd_t             cell_cmd;
    logic [ELEM_BITS-1:0]          wdata;
    logic [ELEM_BITS-1:0]          rd_any;
    logic [ELEM_BITS-1:0]          cell_q  [DEPTH];
    logic [ELEM_BITS-1:0]          cell_rd [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // ---------------------------------------------------------------
    // capacity and positions, all in a common compare width
    // ---------------------------------------------------------------
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(position);
    assign last_ext = (count_reg == '0) ? '0 : cnt_ext - CMP_W'(1);
    assign max_ext  = CMP_W'(max_entries_reg);
    // a register value above DEPTH acts as DEPTH
    assign cap_ext  = (max_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : max_ext;

    // effective position: the stack and queue forms pin it to an end
    always_comb
    begin
        case (func)
            pal_pkg::FN_PUSH:                           epos = cnt_ext;
            pal_pkg::FN_POP_END, pal_pkg::FN_PEEK_END:  epos = last_ext;
            pal_pkg::FN_POP_START, pal_pkg::FN_PEEK_START: epos = '0;
            default:                                    epos = pos_ext;
        endcase
    end

    // ---------------------------------------------------------------
    // checks and command decode; a failed item changes nothing
    // ---------------------------------------------------------------
    always_comb
    begin
        st         = pal_pkg::ST_OK;
        cmd        = '0;
        rd_en      = 1'b0;
        count_next = count_reg;
        case (func)
            pal_pkg::FN_INSERT, pal_pkg::FN_PUSH:
            begin
                if (cnt_ext >= cap_ext)
                    st = pal_pkg::ST_FULL;
                else if (epos > cnt_ext)
                    st = pal_pkg::ST_BADPOS;
                else
                begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            pal_pkg::FN_GET, pal_pkg::FN_SET, pal_pkg::FN_REMOVE,
            pal_pkg::FN_POP_END, pal_pkg::FN_POP_START,
            pal_pkg::FN_PEEK_END, pal_pkg::FN_PEEK_START:
            begin
                if (count_reg == '0)
                    st = pal_pkg::ST_EMPTY;
                else if (epos >= cnt_ext)
                    st = pal_pkg::ST_BADPOS;
                else
                begin
                    rd_en = (func != pal_pkg::FN_SET);
                    if (func == pal_pkg::FN_SET)
                        cmd.wr = 1'b1;
                    if (func inside {pal_pkg::FN_REMOVE, pal_pkg::FN_POP_END,
                                     pal_pkg::FN_POP_START})
                    begin
                        cmd.rem    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // unused codes: no operation, status ok
                st = pal_pkg::ST_OK;
            end
        endcase
    end

    assign cell_cmd = accept ? cmd : '0;
    assign wdata    = ELEM_BITS'(data_in);

    // ---------------------------------------------------------------
    // cell row: cell i hands its word to i+1 on insert, to i-1 on remove
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_BITS-1:0] lower_w;
        logic [ELEM_BITS-1:0] upper_w;

        if (i == 0)
        begin : g_lo_end
            assign lower_w = '0;
        end
        else
        begin : g_lo
            assign lower_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_hi_end
            assign upper_w = '0;
        end
        else
        begin : g_hi
            assign upper_w = cell_q[i+1];
        end

        pal_cell #(
            .CNT_W     (CNT_W),
            .ELEM_BITS (ELEM_BITS),
            .IDX       (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cell_cmd),
            .pos   (CNT_W'(epos)),
            .wdata (wdata),
            .lower (lower_w),
            .upper (upper_w),
            .q     (cell_q[i]),
            .rd    (cell_rd[i])
        );
    end

    // only the addressed cell drives a non-zero word
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_any = rd_any | cell_rd[i];
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            max_entries_reg <= pal_pkg::CFG_W'(CAP_RST);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_entries_reg <= cfg_wr_data;
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg  <= rd_en ? pal_pkg::DATA_W'(rd_any) : '0;
            status_reg    <= st;
            count_out_reg <= pal_pkg::COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

### rtl/pal_checker.sv
// pal_checker: port-level assertions for positional_array_list_unit, bound to
// the top level below. Uses pal_pkg.
`timescale 1ns / 1ps

module pal_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [pal_pkg::DATA_W-1:0]      data_out,
    input  logic [pal_pkg::STATUS_W-1:0]    status,
    input  logic [pal_pkg::COUNT_W-1:0]     count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out)
            && $stable(status) && $stable(count))
        else $error("result changed while stalled");

    // every accepted item yields a result next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // an empty answer only comes from an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pal_pkg::ST_EMPTY |-> count == '0)
        else $error("empty status with non-zero count");

    // failed items return no data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pal_pkg::ST_OK |-> data_out == '0)
        else $error("error result carries data");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .status    (status),
    .count     (count)
);

### tb/positional_array_list_unit_tb.sv
// Self-checking testbench for positional_array_list_unit: directed and random request
// items, a built-in list predictor, random idling on both channels and back-pressure.
// Depends on pal_pkg and the positional_array_list_unit RTL.
`timescale 1ns / 1ps

module positional_array_list_unit_tb;

    localparam int LIST_DEPTH   = 64;
    localparam int HOLD_CYCLES  = 150;      // receiver hold-off for the back-pressure test
    localparam int SETTLE       = 4;        // spare edges waited after the last result arrives
    localparam int CYCLE_LIMIT  = 100000;   // watchdog limit on the whole run
    localparam int IDLE_PCT     = 33;

    // one result item as the predictor expects it
    typedef struct packed {
        logic [pal_pkg::DATA_W-1:0]   data;
        logic [pal_pkg::STATUS_W-1:0] status;
        logic [pal_pkg::COUNT_W-1:0]  count;
    } list_result_t;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ---------------------------------------------------------------------
    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic [pal_pkg::FUNC_W-1:0]   func        = '0;
    logic [pal_pkg::POS_W-1:0]    position    = '0;
    logic [pal_pkg::DATA_W-1:0]   data_in     = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic [pal_pkg::DATA_W-1:0]   data_out;
    logic [pal_pkg::STATUS_W-1:0] status;
    logic [pal_pkg::COUNT_W-1:0]  count;
    logic                         cfg_wr_en   = 1'b0;
    logic [pal_pkg::CFG_W-1:0]    cfg_wr_data = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positional_array_list_unit #(
        .DEPTH     (LIST_DEPTH),
        .ELEM_BITS (pal_pkg::DATA_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .position    (position),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .status      (status),
        .count       (count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ---------------------------------------------------------------------
    // Shared bookkeeping
    // ---------------------------------------------------------------------
    list_result_t pending_results[$];   // expected results, oldest first
    int           items_sent    = 0;    // request items accepted (sender side)
    int           results_seen  = 0;    // result items accepted
    int           fail_count    = 0;
    int           cap_writes    = 0;
    int           status_tally[4] = '{0, 0, 0, 0};

    // idling control, written with nonblocking assignments by the test sequence
    logic         no_idle       = 1'b0; // long stretch where neither side idles
    int           hold_requests = 0;    // bumped to ask the receiver for a hold-off

    // ---------------------------------------------------------------------
    // List predictor: its own copy of the store, fill count and capacity.
    // Cells are only read below the fill count, so they are always written.
    // ---------------------------------------------------------------------
    logic [pal_pkg::DATA_W-1:0] list_cells [LIST_DEPTH];
    int                         list_fill = 0;
    logic [pal_pkg::CFG_W-1:0]  list_cap  = pal_pkg::CFG_W'(LIST_DEPTH);

    // empty takes priority over a position at or past the end
    function automatic logic [pal_pkg::STATUS_W-1:0] read_status(input int p);
        if (list_fill == 0)
            return pal_pkg::ST_EMPTY;
        if (p >= list_fill)
            return pal_pkg::ST_BADPOS;
        return pal_pkg::ST_OK;
    endfunction

    function automatic list_result_t apply_request(input logic [pal_pkg::FUNC_W-1:0] fn,
                                                   input logic [pal_pkg::POS_W-1:0]  pos,
                                                   input logic [pal_pkg::DATA_W-1:0] din);
        list_result_t r;
        int cap;
        int last;
        int p;
        int i;
        // a capacity above the built depth behaves as the depth; zero means always full
        cap  = (int'(list_cap) > LIST_DEPTH) ? LIST_DEPTH : int'(list_cap);
        last = (list_fill == 0) ? 0 : list_fill - 1;
        r.data   = '0;
        r.status = pal_pkg::ST_OK;
        case (fn)
            pal_pkg::FN_INSERT, pal_pkg::FN_PUSH:
            begin
                p = (fn == pal_pkg::FN_PUSH) ? list_fill : int'(pos);
                // full is checked before the position
                if (list_fill >= cap)
                    r.status = pal_pkg::ST_FULL;
                else if (p > list_fill)
                    r.status = pal_pkg::ST_BADPOS;
                else
                begin
                    for (i = list_fill; i > p; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[p] = din;
                    list_fill++;
                end
            end
            pal_pkg::FN_GET, pal_pkg::FN_SET, pal_pkg::FN_PEEK_END, pal_pkg::FN_PEEK_START:
            begin
                p = (fn == pal_pkg::FN_PEEK_END) ? last
                  : (fn == pal_pkg::FN_PEEK_START) ? 0 : int'(pos);
                r.status = read_status(p);
                if (r.status == pal_pkg::ST_OK)
                begin
                    if (fn == pal_pkg::FN_SET)
                        list_cells[p] = din;
                    else
                        r.data = list_cells[p];
                end
            end
            pal_pkg::FN_REMOVE, pal_pkg::FN_POP_END, pal_pkg::FN_POP_START:
            begin
                p = (fn == pal_pkg::FN_POP_END) ? last
                  : (fn == pal_pkg::FN_POP_START) ? 0 : int'(pos);
                r.status = read_status(p);
                if (r.status == pal_pkg::ST_OK)
                begin
                    r.data = list_cells[p];
                    for (i = p; i + 1 < list_fill; i++)
                        list_cells[i] = list_cells[i+1];
                    list_fill--;
                end
            end
            default: ;  // codes 9..15 do nothing and answer ok
        endcase
        r.count = pal_pkg::COUNT_W'(list_fill);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation,
    // then predicts the result of any item accepted at the same edge.
    // All samples are pre-edge values, so the order of processes does not matter.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    note_failure($sformatf("unexpected result: data %h status %0d count %0d",
                                           data_out, status, count));
                else
                begin
                    want = pending_results.pop_front();
                    status_tally[want.status]++;
                    if (data_out !== want.data || status !== want.status
                        || count !== want.count)
                        note_failure($sformatf(
                            "want data %h status %0d count %0d, got data %h status %0d count %0d",
                            want.data, want.status, want.count, data_out, status, count));
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(apply_request(func, position, data_in));
            if (cfg_wr_en)
                list_cap = cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, a quiet stretch, and hold-offs on request.
    // ---------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("positional_array_list_unit_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Sender side. Tasks are entered just after a rising edge.
    // Valid stays up, payload unchanged, until the item is taken.
    // ---------------------------------------------------------------------
    task automatic send_request(input logic [pal_pkg::FUNC_W-1:0] fn,
                                input logic [pal_pkg::POS_W-1:0]  pos,
                                input logic [pal_pkg::DATA_W-1:0] din);
        in_valid <= 1'b1;
        func     <= fn;
        position <= pos;
        data_in  <= din;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        // random gap after the item; valid is left high when there is none
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
    endtask

    // sender pause: wait for every expected result, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // capacity is only changed while the block is idle
    task automatic write_capacity(input logic [pal_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic [pal_pkg::DATA_W-1:0] pick_data();
        if ($urandom_range(9) != 0)
            return $urandom;
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // grow_pct steers the fill level: inserts/pushes versus removes/pops
    task automatic send_random_request(input int grow_pct);
        int                         r;
        logic [pal_pkg::FUNC_W-1:0] fn;
        logic [pal_pkg::POS_W-1:0]  pos;
        r = $urandom_range(99);
        if (r < 3)
            fn = pal_pkg::FUNC_W'($urandom_range(15, 9));
        else if (r < 3 + grow_pct)
            fn = ($urandom_range(1) != 0) ? pal_pkg::FN_INSERT : pal_pkg::FN_PUSH;
        else if (r < 78)
            case ($urandom_range(2))
                0:       fn = pal_pkg::FN_REMOVE;
                1:       fn = pal_pkg::FN_POP_END;
                default: fn = pal_pkg::FN_POP_START;
            endcase
        else
            case ($urandom_range(3))
                0:       fn = pal_pkg::FN_GET;
                1:       fn = pal_pkg::FN_SET;
                2:       fn = pal_pkg::FN_PEEK_END;
                default: fn = pal_pkg::FN_PEEK_START;
            endcase
        // mostly positions that reach the list (fill read only to bias the choice)
        if ($urandom_range(99) < 85)
            pos = pal_pkg::POS_W'($urandom_range(list_fill));
        else
            pos = pal_pkg::POS_W'($urandom_range(127));
        send_request(fn, pos, pick_data());
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // every read-type operation on an empty list answers empty; an insert at 1 gets BADPOS
    task automatic test_empty_list();
        send_request(pal_pkg::FN_GET,        7'd0,   32'h1111_1111);
        send_request(pal_pkg::FN_SET,        7'd0,   32'h2222_2222);
        send_request(pal_pkg::FN_REMOVE,     7'd0,   '0);
        send_request(pal_pkg::FN_POP_END,    7'd0,   '0);
        send_request(pal_pkg::FN_POP_START,  7'd0,   '0);
        send_request(pal_pkg::FN_PEEK_END,   7'd0,   '0);
        send_request(pal_pkg::FN_PEEK_START, 7'd0,   '0);
        send_request(pal_pkg::FN_INSERT,     7'd1,   32'h3333_3333);   // past the end
    endtask

    // insert/remove shifting and position bounds; leaves the list empty
    task automatic test_positions();
        send_request(pal_pkg::FN_INSERT,     7'd0,   '1);
        send_request(pal_pkg::FN_PUSH,       7'd99,  '0);              // position ignored
        send_request(pal_pkg::FN_INSERT,     7'd1,   32'hA5A5_A5A5);   // middle
        send_request(pal_pkg::FN_INSERT,     7'd3,   32'h0000_0001);   // at the end
        send_request(pal_pkg::FN_INSERT,     7'd5,   32'hDEAD_BEEF);   // beyond the end
        send_request(pal_pkg::FN_GET,        7'd4,   '0);              // position == count
        send_request(pal_pkg::FN_GET,        7'd127, '0);
        send_request(pal_pkg::FN_SET,        7'd2,   32'h8000_0000);
        send_request(pal_pkg::FN_GET,        7'd2,   '0);
        send_request(pal_pkg::FN_REMOVE,     7'd1,   '0);
        send_request(pal_pkg::FN_PEEK_END,   7'd0,   '0);
        send_request(pal_pkg::FN_PEEK_START, 7'd0,   '0);
        send_request(pal_pkg::FN_POP_END,    7'd0,   '0);
        send_request(pal_pkg::FN_POP_START,  7'd0,   '0);
        send_request(pal_pkg::FN_REMOVE,     7'd0,   '0);
    endtask

    // unused codes answer ok with no change
    task automatic test_unused_codes();
        send_request(pal_pkg::FUNC_W'(9),  7'd0,   32'hFFFF_FFFF);
        send_request(pal_pkg::FUNC_W'(15), 7'd127, 32'h5555_5555);
    endtask

    // capacity of one, zero, above the depth, and lowered below the count
    task automatic test_capacity_limits();
        write_capacity(pal_pkg::CFG_W'(1));
        send_request(pal_pkg::FN_PUSH,      7'd0,   32'h0BAD_F00D);
        send_request(pal_pkg::FN_PUSH,      7'd0,   32'h1234_5678);
        send_request(pal_pkg::FN_INSERT,    7'd127, '0);           // full wins over position
        send_request(pal_pkg::FN_POP_START, 7'd0,   '0);
        write_capacity(pal_pkg::CFG_W'(0));
        send_request(pal_pkg::FN_PUSH,      7'd0,   '1);
        send_request(pal_pkg::FN_INSERT,    7'd0,   '1);
        send_request(pal_pkg::FN_GET,       7'd0,   '0);
        write_capacity(pal_pkg::CFG_W'(127));                      // acts as the full depth
        repeat (LIST_DEPTH)
            send_request(pal_pkg::FN_PUSH, pal_pkg::POS_W'($urandom_range(127)), pick_data());
        send_request(pal_pkg::FN_PUSH,       7'd0,  '0);
        send_request(pal_pkg::FN_INSERT,     7'd0,  '0);
        send_request(pal_pkg::FN_PEEK_END,   7'd0,  '0);
        send_request(pal_pkg::FN_GET,        7'd63, '0);
        write_capacity(pal_pkg::CFG_W'(10));                       // now below the count
        send_request(pal_pkg::FN_PUSH,      7'd0,  '0);
        send_request(pal_pkg::FN_REMOVE,    7'd5,  '0);
        send_request(pal_pkg::FN_INSERT,    7'd5,  32'hCAFE_0000);
        send_request(pal_pkg::FN_GET,       7'd62, '0);
    endtask

    // receiver holds off while the sender keeps offering: the block must stall
    task automatic test_backpressure();
        write_capacity(pal_pkg::CFG_W'(LIST_DEPTH));
        hold_requests <= hold_requests + 1;
        repeat (30)
            send_random_request(40);
        wait_drained();
    endtask

    // random phases over a spread of capacities and fill trends
    task automatic test_random_mix();
        int caps[8]  = '{64, 64, 3, 1, 0, 127, 10, 64};
        int grow[8]  = '{45, 20, 40, 40, 40, 55, 40, 35};
        int items[8] = '{300, 200, 150, 100, 60, 300, 200, 240};
        int ph;
        for (ph = 0; ph < 8; ph++)
        begin
            write_capacity(pal_pkg::CFG_W'(caps[ph]));
            no_idle <= (ph == 0);   // first phase runs with no idling at all
            repeat (items[ph])
                send_random_request(grow[ph]);
        end
        no_idle <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_positions();
        test_unused_codes();
        test_capacity_limits();
        test_backpressure();
        test_random_mix();

        wait_drained();
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_results.size()));

        $display("Checked %0d results over %0d capacity writes, incl. a %0d-cycle output hold.",
                 results_seen, cap_writes, HOLD_CYCLES);
        $display("Status mix: %0d ok, %0d full, %0d empty, %0d bad position; %0d failures.",
                 status_tally[pal_pkg::ST_OK], status_tally[pal_pkg::ST_FULL],
                 status_tally[pal_pkg::ST_EMPTY], status_tally[pal_pkg::ST_BADPOS],
                 fail_count);
        if (fail_count == 0)
            $display("positional_array_list_unit_tb passed");
        else
            $display("positional_array_list_unit_tb failed");
        $finish;
    end

endmodule
